FILE: rtl/fnv1hb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnv1hb_pkg: shared types and constants for the FNV-1 bucket hasher
// Widths, FNV constants, the shift-add schedule for the prime multiply,
// the sequencer states and the shared unit's operation codes.
// ----------------------------------------------------------------------------
package fnv1hb_pkg;

  localparam int unsigned KEY_W  = 8;
  localparam int unsigned HASH_W = 32;

  localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;

  // Prime 16777619 = 2^24 + 2^8 + 2^7 + 2^4 + 2^1 + 2^0.
  // The 2^0 term seeds the accumulator; the rest are added one per cycle.
  localparam int unsigned MUL_STEPS = 5;
  localparam int unsigned SHAMT_W   = $clog2(HASH_W);
  localparam int unsigned MSTEP_W   = $clog2(MUL_STEPS);
  localparam logic [SHAMT_W-1:0] MUL_SHIFT [MUL_STEPS] =
    '{5'd1, 5'd4, 5'd7, 5'd8, 5'd24};

  // One remainder bit per cycle in the restoring divider
  localparam int unsigned DIV_STEPS = HASH_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef enum logic {
    ALU_ADD_SHIFT,
    ALU_TRIAL_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t            op;
    logic [SHAMT_W-1:0] shamt;
  } alu_ctrl_t;

endpackage

FILE: rtl/fnv1hb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnv1hb_if: valid/ready channels of the FNV-1 bucket hasher
// Key byte input, bucket index output and bucket count write channel.
// ----------------------------------------------------------------------------
interface fnv1hb_key_if;
  import fnv1hb_pkg::*;
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_byte;

  modport source (output valid, output key_byte, input ready);
  modport sink   (input valid, input key_byte, output ready);
endinterface

interface fnv1hb_bucket_if;
  import fnv1hb_pkg::*;
  logic              valid;
  logic              ready;
  logic [HASH_W-1:0] bucket_index;

  modport source (output valid, output bucket_index, input ready);
  modport sink   (input valid, input bucket_index, output ready);
endinterface

interface fnv1hb_cfg_if;
  import fnv1hb_pkg::*;
  logic              valid;
  logic              ready;
  logic [HASH_W-1:0] bucket_count;

  modport source (output valid, output bucket_count, input ready);
  modport sink   (input valid, input bucket_count, output ready);
endinterface

FILE: rtl/fnv1_hash_bucket.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnv1_hash_bucket: FNV-1 32-bit key hash reduced to a bucket index
// Hashes a zero-terminated key byte by byte and, at the terminator, emits
// the hash modulo the configured bucket count.
// ----------------------------------------------------------------------------
//  channel | dir | payload              | beat
//  key     | in  | key_byte     [7:0]   | one key byte, zero ends the key
//  bucket  | out | bucket_index [31:0]  | one index per terminated key
//  cfg     | in  | bucket_count [31:0]  | bucket count write
//
//  A nonzero byte runs the accept, then five shift-add passes of the prime
//  multiply through the shared adder. A terminator runs the accept, 32
//  restoring-division steps, then one load of the output register. Count
//  writes wait while the divide and the load run. A zero count returns
//  the full hash. rst (synchronous) sets the hash to the basis and the
//  count to 1. A stalled index beat holds the block only at the load.
// ----------------------------------------------------------------------------
module fnv1_hash_bucket (
  input  logic                   clk,
  input  logic                   rst,
  fnv1hb_key_if.sink             key,
  fnv1hb_bucket_if.source        bucket,
  fnv1hb_cfg_if.sink             cfg
);
  import fnv1hb_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [HASH_W-1:0] hash;
  logic [HASH_W-1:0] acc;
  logic [KEY_W-1:0]  byte_q;
  logic [HASH_W-1:0] dvd;
  logic [HASH_W-1:0] rem;
  logic [CNT_W-1:0]  cnt;
  logic [HASH_W-1:0] bucket_count;
  logic [HASH_W-1:0] res_q;
  logic              res_valid;

  alu_ctrl_t         alu_ctrl;
  logic [HASH_W-1:0] alu_sum;
  logic              alu_no_borrow;
  logic [HASH_W:0]   rem_shift;

  logic              in_fire;
  logic              cfg_fire;
  logic              res_load;
  logic              mul_last;
  logic              div_last;

  // shared arithmetic unit
  fnv1hb_alu u_alu (
    .ctrl      (alu_ctrl),
    .acc       (acc),
    .hash      (hash),
    .rem       (rem),
    .dvd_msb   (dvd[HASH_W-1]),
    .divisor   (bucket_count),
    .sum       (alu_sum),
    .no_borrow (alu_no_borrow)
  );

  assign rem_shift = {rem, dvd[HASH_W-1]};
  assign mul_last  = (cnt == CNT_W'(MUL_STEPS - 1));
  assign div_last  = (cnt == CNT_W'(DIV_STEPS - 1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (key.valid) begin
          state_next = (key.key_byte != '0) ? ST_MUL : ST_DIV;
        end
      end
      ST_MUL: begin
        if (mul_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_last) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!res_valid || bucket.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    key.ready      = 1'b0;
    res_load       = 1'b0;
    alu_ctrl.op    = ALU_ADD_SHIFT;
    alu_ctrl.shamt = '0;
    unique case (state)
      ST_IDLE: key.ready = 1'b1;
      ST_MUL: begin
        alu_ctrl.op    = ALU_ADD_SHIFT;
        alu_ctrl.shamt = MUL_SHIFT[cnt[MSTEP_W-1:0]];
      end
      ST_DIV:  alu_ctrl.op = ALU_TRIAL_SUB;
      ST_FIN:  res_load    = !res_valid || bucket.ready;
      default: key.ready   = 1'b0;
    endcase
  end

  assign in_fire  = key.valid && key.ready;
  assign cfg_fire = cfg.valid && cfg.ready;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      hash         <= FNV_BASIS;
      bucket_count <= HASH_W'(1);
      res_valid    <= 1'b0;
      cnt          <= '0;
    end else begin
      state <= state_next;
      if (cfg_fire) begin
        bucket_count <= cfg.bucket_count;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (bucket.ready) begin
        res_valid <= 1'b0;
      end
      if (in_fire) begin
        cnt <= '0;
        if (key.key_byte == '0) begin
          hash <= FNV_BASIS;
        end
      end else if (state == ST_MUL || state == ST_DIV) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (state == ST_MUL && mul_last) begin
        hash <= alu_sum ^ {{(HASH_W-KEY_W){1'b0}}, byte_q};
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      byte_q <= key.key_byte;
      acc    <= hash;
      dvd    <= hash;
      rem    <= '0;
    end
    if (state == ST_MUL) begin
      acc <= alu_sum;
    end
    if (state == ST_DIV) begin
      dvd <= dvd << 1;
      rem <= alu_no_borrow ? alu_sum : rem_shift[HASH_W-1:0];
    end
    if (res_load) begin
      res_q <= rem;
    end
  end

  // divisor stays put while a divide and its load are running
  assign cfg.ready           = (state == ST_IDLE) || (state == ST_MUL);
  assign bucket.valid        = res_valid;
  assign bucket.bucket_index = res_q;

  // terminator restores the offset basis
  a_term_basis: assert property (@(posedge clk) disable iff (rst)
    in_fire && key.key_byte == '0 |=> hash == FNV_BASIS)
    else $error("hash not reset to basis after terminator");

  // loaded index stays below a nonzero bucket count
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    res_load |=> bucket_count == '0 || res_q < bucket_count)
    else $error("bucket index out of range");

  // multiply schedule never runs past its table
  a_mul_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL |-> cnt < CNT_W'(MUL_STEPS))
    else $error("multiply step count overrun");

  // a pending index is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> !res_valid || bucket.ready)
    else $error("index overwritten while stalled");

endmodule

FILE: rtl/fnv1hb_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnv1hb_alu: shared adder/subtractor
// Either adds a shifted copy of the hash to the product accumulator, or
// does the trial subtract of the divisor from the shifted partial remainder.
// ----------------------------------------------------------------------------
module fnv1hb_alu (
  input  fnv1hb_pkg::alu_ctrl_t            ctrl,
  input  logic [fnv1hb_pkg::HASH_W-1:0]    acc,
  input  logic [fnv1hb_pkg::HASH_W-1:0]    hash,
  input  logic [fnv1hb_pkg::HASH_W-1:0]    rem,
  input  logic                             dvd_msb,
  input  logic [fnv1hb_pkg::HASH_W-1:0]    divisor,
  output logic [fnv1hb_pkg::HASH_W-1:0]    sum,
  output logic                             no_borrow
);
  import fnv1hb_pkg::*;

  logic              sub;
  logic [HASH_W:0]   opa;
  logic [HASH_W:0]   opb;
  logic [HASH_W:0]   opb_inv;
  logic [HASH_W+1:0] full;

  // operand select
  always_comb begin
    sub = (ctrl.op == ALU_TRIAL_SUB);
    if (sub) begin
      opa = {rem, dvd_msb};
      opb = {1'b0, divisor};
    end else begin
      opa = {1'b0, acc};
      opb = {1'b0, hash << ctrl.shamt};
    end
    opb_inv = sub ? ~opb : opb;
  end

  // single carry chain; carry out of a subtract means no borrow
  assign full      = {1'b0, opa} + {1'b0, opb_inv} + {{(HASH_W+1){1'b0}}, sub};
  assign sum       = full[HASH_W-1:0];
  assign no_borrow = full[HASH_W+1];

endmodule
